// ===== rtl/slts_pkg.sv =====
// Shared types, codes and field positions for the SPI link transfer sequencer.
package slts_pkg;

  // Defaults for the top-level parameters
  localparam int MTU_BYTES_DEF    = 1024;
  localparam int HEADER_BYTES_DEF = 4;

  // Compare width: wide enough for any MTU, header length or head+tail sum
  localparam int WIDE_W = 17;

  // Field widths
  localparam int KIND_W  = 2;
  localparam int BYTES_W = 11;
  localparam int HLEN_W  = 16;
  localparam int PHASE_W = 2;
  localparam int SRC_W   = 2;
  localparam int ERR_W   = 2;

  // Input request packing
  localparam int S_TDATA_W = 40;
  localparam int S_HEAD_LO = 0;
  localparam int S_TAIL_LO = 11;
  localparam int S_HLEN_LO = 22;

  // Result packing (cmd_phase travels in tuser)
  localparam int M_TDATA_W    = 24;
  localparam int M_READY_BIT  = 0;
  localparam int M_VALID_BIT  = 1;
  localparam int M_BYTES_LO   = 2;
  localparam int M_REL_BIT    = 13;
  localparam int M_SRC_LO     = 14;
  localparam int M_RX_BIT     = 16;
  localparam int M_SDONE_BIT  = 17;
  localparam int M_RDONE_BIT  = 18;
  localparam int M_ERR_LO     = 19;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_SEND = 2'd0;
  localparam logic [KIND_W-1:0] KIND_RECV = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PEER = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE = 2'd3;

  // Phase codes
  localparam logic [PHASE_W-1:0] PH_HEADER = 2'd0;
  localparam logic [PHASE_W-1:0] PH_HEAD   = 2'd1;
  localparam logic [PHASE_W-1:0] PH_TAIL   = 2'd2;
  localparam logic [PHASE_W-1:0] PH_DUMMY  = 2'd3;

  // Transmit sources
  localparam logic [SRC_W-1:0] SRC_NONE  = 2'd0;
  localparam logic [SRC_W-1:0] SRC_DATA  = 2'd1;
  localparam logic [SRC_W-1:0] SRC_EMPTY = 2'd2;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
  localparam logic [ERR_W-1:0] ERR_SEND_BUSY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_RECV_BUSY = 2'd2;
  localparam logic [ERR_W-1:0] ERR_BAD_LEN   = 2'd3;

  typedef enum logic [5:0] {
    ST_IDLE      = 6'b000001,
    ST_WAIT_RECV = 6'b000010,
    ST_WAIT_PEER = 6'b000100,
    ST_HDR       = 6'b001000,
    ST_HEAD      = 6'b010000,
    ST_TAIL      = 6'b100000
  } state_t;

endpackage

// ===== rtl/spi_link_transfer_sequencer.sv =====
// Top level of the SPI link transfer sequencer.
// Takes one event per request on the s_ side (kind in s_tuser) and returns exactly one
// result per request on the m_ side, in the cycle after the request is taken. A new request
// is taken in every cycle while the result register is empty or being drained, so the
// block sustains one request per clock; the only stored element between the two sides is
// the single result register. The bidirectional flag is written on the cfg channel, which
// is always ready. Lengths are bytes; the tail phase length is rounded up to 4 bytes.
module spi_link_transfer_sequencer
  import slts_pkg::*;
#(
  parameter int MTU_BYTES    = MTU_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  // request: head_bytes[10:0], tail_bytes[21:11], rx_header_length[37:22], zero pad
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_TDATA_W-1:0]  s_tdata,
  // request: kind[1:0]
  input  logic [KIND_W-1:0]     s_tuser,
  // result: ready_line[0], cmd_valid[1], cmd_bytes[12:2], cmd_release_cs[13],
  // cmd_tx_source[15:14], cmd_rx[16], tx_complete[17], rx_complete[18], error[20:19], pad
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_TDATA_W-1:0]  m_tdata,
  // result: cmd_phase[1:0]
  output logic [PHASE_W-1:0]    m_tuser,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_data
);

  localparam int LEN_W = $clog2(MTU_BYTES + 4);

  state_t             state, state_next;
  logic               send_pending, send_pending_next;
  logic               receive_pending, receive_pending_next;
  logic               peer_ready, peer_ready_next;
  logic               send_latched, send_latched_next;
  logic               receive_latched, receive_latched_next;
  logic [LEN_W-1:0]   send_head_len, send_head_len_next;
  logic [LEN_W-1:0]   send_total_len, send_total_len_next;
  logic [LEN_W-1:0]   recv_len, recv_len_next;
  logic               ready_level, ready_level_next;
  logic               bidirectional;

  logic [BYTES_W-1:0] head_in, tail_in;
  logic [HLEN_W-1:0]  hlen_in;
  logic [WIDE_W-1:0]  sum_in;
  logic               bad_len;
  logic [LEN_W-1:0]   cur_head, send_tot, cur_total, rem, rem_up;
  logic               take;

  // result fields
  logic               cmd_valid;
  logic [PHASE_W-1:0] cmd_phase;
  logic [BYTES_W-1:0] cmd_bytes;
  logic               cmd_rel;
  logic [SRC_W-1:0]   cmd_src;
  logic               cmd_rx;
  logic               tx_complete, rx_complete;
  logic [ERR_W-1:0]   err;
  logic [M_TDATA_W-1:0] result_word;

  assign take      = s_tvalid && s_tready;
  assign s_tready  = !m_tvalid || m_tready;
  assign cfg_ready = 1'b1;

  assign head_in = s_tdata[S_HEAD_LO +: BYTES_W];
  assign tail_in = s_tdata[S_TAIL_LO +: BYTES_W];
  assign hlen_in = s_tdata[S_HLEN_LO +: HLEN_W];
  assign sum_in  = WIDE_W'(head_in) + WIDE_W'(tail_in);
  assign bad_len = (head_in[1:0] != 2'd0) || (tail_in[1:0] != 2'd0)
                   || (sum_in > WIDE_W'(MTU_BYTES));

  // Received length as seen by the current event (updated at header done)
  always_comb begin
    recv_len_next = recv_len;
    if (s_tuser == KIND_DONE && state == ST_HDR) begin
      recv_len_next = '0;
      if (receive_latched && bidirectional) begin
        if (WIDE_W'(hlen_in) < WIDE_W'(MTU_BYTES)) recv_len_next = LEN_W'(hlen_in);
        else recv_len_next = LEN_W'(MTU_BYTES);
      end
    end
  end

  assign cur_head  = send_latched ? send_head_len : '0;
  assign send_tot  = send_latched ? send_total_len : '0;
  assign cur_total = (send_tot > recv_len_next) ? send_tot : recv_len_next;
  assign rem       = cur_total - cur_head;
  assign rem_up    = (rem + LEN_W'(3)) & ~LEN_W'(3);

  always_comb begin
    state_next           = state;
    send_pending_next    = send_pending;
    receive_pending_next = receive_pending;
    peer_ready_next      = peer_ready;
    send_latched_next    = send_latched;
    receive_latched_next = receive_latched;
    send_head_len_next   = send_head_len;
    send_total_len_next  = send_total_len;
    ready_level_next     = ready_level;
    cmd_valid   = 1'b0;
    cmd_phase   = PH_HEADER;
    cmd_bytes   = '0;
    cmd_rel     = 1'b0;
    cmd_src     = SRC_NONE;
    cmd_rx      = 1'b0;
    tx_complete = 1'b0;
    rx_complete = 1'b0;
    err         = ERR_NONE;

    unique case (s_tuser)
      KIND_SEND: begin
        if (send_pending) begin
          err = ERR_SEND_BUSY;
        end else if (bad_len) begin
          err = ERR_BAD_LEN;
        end else begin
          send_pending_next   = 1'b1;
          send_head_len_next  = LEN_W'(head_in);
          send_total_len_next = LEN_W'(sum_in);
        end
      end
      KIND_RECV: begin
        if (receive_pending) err = ERR_RECV_BUSY;
        else receive_pending_next = 1'b1;
      end
      KIND_PEER: begin
        peer_ready_next = 1'b1;
      end
      KIND_DONE: begin
        if (state == ST_HDR) begin
          ready_level_next = 1'b0;
          peer_ready_next  = 1'b0;
          if (cur_head == '0) begin
            if (cur_total == '0) begin
              // nothing to move: release chip select with a dummy header
              cmd_valid  = 1'b1;
              cmd_phase  = PH_DUMMY;
              cmd_bytes  = BYTES_W'(HEADER_BYTES);
              cmd_rel    = 1'b1;
              cmd_src    = SRC_EMPTY;
              state_next = ST_HEAD;
            end else begin
              cmd_valid  = 1'b1;
              cmd_phase  = PH_TAIL;
              cmd_bytes  = BYTES_W'(WIDE_W'(rem_up));
              cmd_rel    = 1'b1;
              cmd_src    = send_latched ? SRC_DATA : SRC_NONE;
              cmd_rx     = receive_latched;
              state_next = ST_TAIL;
            end
          end else begin
            cmd_valid  = 1'b1;
            cmd_phase  = PH_HEAD;
            cmd_bytes  = BYTES_W'(WIDE_W'(cur_head));
            cmd_rel    = (cur_total == cur_head);
            cmd_src    = SRC_DATA;
            cmd_rx     = receive_latched;
            state_next = ST_HEAD;
          end
        end else if (state == ST_HEAD && cur_total != cur_head) begin
          cmd_valid  = 1'b1;
          cmd_phase  = PH_TAIL;
          cmd_bytes  = BYTES_W'(WIDE_W'(rem_up));
          cmd_rel    = 1'b1;
          cmd_src    = send_latched ? SRC_DATA : SRC_NONE;
          cmd_rx     = receive_latched;
          state_next = ST_TAIL;
        end else if (state == ST_HEAD || state == ST_TAIL) begin
          // exchange complete: pulse done for whatever was joined
          tx_complete = send_latched;
          rx_complete = receive_latched;
          if (send_latched) send_pending_next = 1'b0;
          if (receive_latched) receive_pending_next = 1'b0;
          send_latched_next    = 1'b0;
          receive_latched_next = 1'b0;
          state_next           = ST_IDLE;
        end
      end
    endcase

    // advance through the wait states on the updated flags
    if (state_next == ST_IDLE && (send_pending_next || peer_ready_next)) begin
      state_next = ST_WAIT_RECV;
    end
    if (state_next == ST_WAIT_RECV && receive_pending_next) begin
      if (send_pending_next) ready_level_next = 1'b1;
      state_next = ST_WAIT_PEER;
    end
    if (state_next == ST_WAIT_PEER && peer_ready_next && !cmd_valid) begin
      send_latched_next    = send_pending_next;
      receive_latched_next = receive_pending_next;
      cmd_valid  = 1'b1;
      cmd_phase  = PH_HEADER;
      cmd_bytes  = BYTES_W'(HEADER_BYTES);
      cmd_rel    = 1'b0;
      cmd_src    = send_pending_next ? SRC_DATA : SRC_EMPTY;
      cmd_rx     = receive_pending_next;
      state_next = ST_HDR;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      send_pending    <= 1'b0;
      receive_pending <= 1'b0;
      peer_ready      <= 1'b0;
      send_latched    <= 1'b0;
      receive_latched <= 1'b0;
      send_head_len   <= '0;
      send_total_len  <= '0;
      recv_len        <= '0;
      ready_level     <= 1'b0;
      bidirectional   <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) bidirectional <= cfg_data;
      if (take) begin
        state           <= state_next;
        send_pending    <= send_pending_next;
        receive_pending <= receive_pending_next;
        peer_ready      <= peer_ready_next;
        send_latched    <= send_latched_next;
        receive_latched <= receive_latched_next;
        send_head_len   <= send_head_len_next;
        send_total_len  <= send_total_len_next;
        recv_len        <= recv_len_next;
        ready_level     <= ready_level_next;
        m_tvalid        <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // pack the result fields, lowest bit first, zero pad on top
  assign result_word = {{(M_TDATA_W - M_ERR_LO - ERR_W){1'b0}}, err, rx_complete,
                        tx_complete, cmd_rx, cmd_src, cmd_rel, cmd_bytes, cmd_valid,
                        ready_level_next};

  // result register
  always_ff @(posedge clk) begin
    if (take) begin
      m_tdata <= result_word;
      m_tuser <= cmd_phase;
    end
  end

endmodule

// ===== rtl/slts_checker.sv =====
// Port-level checker for the SPI link transfer sequencer, bound to the top level.
module slts_checker
  import slts_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [S_TDATA_W-1:0] s_tdata,
  input logic [KIND_W-1:0]    s_tuser,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic [PHASE_W-1:0]   m_tuser,
  input logic                 cfg_valid,
  input logic                 cfg_ready,
  input logic                 cfg_data
);

  // hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // every taken request yields a result on the next cycle
  a_result: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("request produced no result");

  // command fields stay zero when no command is issued
  a_idle_cmd: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[M_VALID_BIT] |->
      m_tdata[M_RX_BIT:M_BYTES_LO] == '0 && m_tuser == PH_HEADER)
    else $error("command fields set without a command");

  // a rejected request never completes an exchange or issues a command
  a_err_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[M_ERR_LO +: ERR_W] != ERR_NONE |->
      !m_tdata[M_SDONE_BIT] && !m_tdata[M_RDONE_BIT] && !m_tdata[M_VALID_BIT])
    else $error("done pulse or command with an error");

endmodule

bind spi_link_transfer_sequencer slts_checker u_slts_checker (.*);

// ===== tb/slts_link_checker.sv =====
`timescale 1ns / 1ps
// Link exchange checker: watches the request, result and register channels and predicts results.
module slts_link_checker
  import slts_pkg::*;
#(
  parameter int MTU_BYTES    = MTU_BYTES_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,
  input  logic [KIND_W-1:0]    s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [M_TDATA_W-1:0] m_tdata,
  input  logic [PHASE_W-1:0]   m_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic                 cfg_data,
  output int                   fail_count,
  output int                   outstanding,
  output int                   results_seen,
  output int                   commands_seen
);

  typedef struct packed {
    logic                ready_line;
    logic                cmd_valid;
    logic [PHASE_W-1:0]  phase;
    logic [BYTES_W-1:0]  bytes;
    logic                rel;
    logic [SRC_W-1:0]    src;
    logic                rx;
    logic                sdone;
    logic                rdone;
    logic [ERR_W-1:0]    err;
  } link_result_t;

  link_result_t expected_results[$];
  link_result_t nxt;

  // Own copy of the sequencer state and the register
  state_t seq_state;
  logic   bidir;
  logic   send_pend, recv_pend, peer_flag;
  logic   send_lat, recv_lat, ready_lvl;
  int     head_len, total_len, rx_len;

  function automatic int latched_head();
    return send_lat ? head_len : 0;
  endfunction

  function automatic int exchange_total();
    int s;
    s = send_lat ? total_len : 0;
    return (s > rx_len) ? s : rx_len;
  endfunction

  task automatic issue_cmd(input logic [PHASE_W-1:0] ph, input int nbytes, input logic rel,
                           input logic [SRC_W-1:0] src, input logic rx);
    nxt.cmd_valid = 1'b1;
    nxt.phase     = ph;
    nxt.bytes     = nbytes[BYTES_W-1:0];
    nxt.rel       = rel;
    nxt.src       = src;
    nxt.rx        = rx;
  endtask

  task automatic close_exchange();
    if (send_lat) begin
      nxt.sdone = 1'b1;
      send_pend = 1'b0;
    end
    if (recv_lat) begin
      nxt.rdone = 1'b1;
      recv_pend = 1'b0;
    end
    send_lat  = 1'b0;
    recv_lat  = 1'b0;
    seq_state = ST_IDLE;
  endtask

  task automatic issue_tail();
    int rem;
    rem = exchange_total() - latched_head();
    rem = (rem + 3) & ~3;
    issue_cmd(PH_TAIL, rem, 1'b1, send_lat ? SRC_DATA : SRC_NONE, recv_lat);
    seq_state = ST_TAIL;
  endtask

  task automatic predict_link_step(input logic [KIND_W-1:0] kind, input int hb, input int tb,
                                   input int hl);
    nxt = '0;
    case (kind)
      KIND_SEND: begin
        if (send_pend) nxt.err = ERR_SEND_BUSY;
        else if ((hb % 4) != 0 || (tb % 4) != 0 || hb + tb > MTU_BYTES) nxt.err = ERR_BAD_LEN;
        else begin
          send_pend = 1'b1;
          head_len  = hb;
          total_len = hb + tb;
        end
      end
      KIND_RECV: begin
        if (recv_pend) nxt.err = ERR_RECV_BUSY;
        else recv_pend = 1'b1;
      end
      KIND_PEER: peer_flag = 1'b1;
      default: begin
        if (seq_state == ST_HDR) begin
          // header done: drop the ready line and re-arm the peer edge
          ready_lvl = 1'b0;
          peer_flag = 1'b0;
          rx_len    = 0;
          if (recv_lat && bidir) rx_len = (hl < MTU_BYTES) ? hl : MTU_BYTES;
          if (latched_head() == 0) begin
            if (exchange_total() == 0) begin
              issue_cmd(PH_DUMMY, HEADER_BYTES, 1'b1, SRC_EMPTY, 1'b0);
              seq_state = ST_HEAD;
            end else begin
              issue_tail();
            end
          end else begin
            issue_cmd(PH_HEAD, latched_head(), exchange_total() == latched_head(), SRC_DATA,
                      recv_lat);
            seq_state = ST_HEAD;
          end
        end else if (seq_state == ST_HEAD) begin
          if (exchange_total() == latched_head()) close_exchange();
          else issue_tail();
        end else if (seq_state == ST_TAIL) begin
          close_exchange();
        end
      end
    endcase

    // advance toward the header phase as far as the pending events allow
    if (seq_state == ST_IDLE && (send_pend || peer_flag)) seq_state = ST_WAIT_RECV;
    if (seq_state == ST_WAIT_RECV && recv_pend) begin
      if (send_pend) ready_lvl = 1'b1;
      seq_state = ST_WAIT_PEER;
    end
    if (seq_state == ST_WAIT_PEER && peer_flag && !nxt.cmd_valid) begin
      send_lat = send_pend;
      recv_lat = recv_pend;
      issue_cmd(PH_HEADER, HEADER_BYTES, 1'b0, send_lat ? SRC_DATA : SRC_EMPTY, recv_lat);
      seq_state = ST_HDR;
    end
    nxt.ready_line = ready_lvl;
    expected_results.push_back(nxt);
  endtask

  task automatic report_mismatch(input string msg);
    fail_count++;
    $display("MISMATCH at %0t: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input int got, input int want);
    if (got != want)
      report_mismatch($sformatf("result %0d field %s: got %0d, expected %0d",
                                results_seen, name, got, want));
  endtask

  always @(posedge clk) begin
    link_result_t got;
    link_result_t want;
    if (rst) begin
      seq_state  = ST_IDLE;
      bidir      = 1'b0;
      send_pend  = 1'b0;
      recv_pend  = 1'b0;
      peer_flag  = 1'b0;
      send_lat   = 1'b0;
      recv_lat   = 1'b0;
      ready_lvl  = 1'b0;
      head_len   = 0;
      total_len  = 0;
      rx_len     = 0;
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) bidir = cfg_data;

      // pop before push: a result never belongs to the request taken at the same edge
      if (m_tvalid && m_tready) begin
        results_seen++;
        got.ready_line = m_tdata[M_READY_BIT];
        got.cmd_valid  = m_tdata[M_VALID_BIT];
        got.phase      = m_tuser;
        got.bytes      = m_tdata[M_BYTES_LO +: BYTES_W];
        got.rel        = m_tdata[M_REL_BIT];
        got.src        = m_tdata[M_SRC_LO +: SRC_W];
        got.rx         = m_tdata[M_RX_BIT];
        got.sdone      = m_tdata[M_SDONE_BIT];
        got.rdone      = m_tdata[M_RDONE_BIT];
        got.err        = m_tdata[M_ERR_LO +: ERR_W];
        if (got.cmd_valid) commands_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request outstanding",
                                    results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("ready_line", int'(got.ready_line), int'(want.ready_line));
          check_field("cmd_valid", int'(got.cmd_valid), int'(want.cmd_valid));
          check_field("cmd_phase", int'(got.phase), int'(want.phase));
          check_field("cmd_bytes", int'(got.bytes), int'(want.bytes));
          check_field("cmd_release_cs", int'(got.rel), int'(want.rel));
          check_field("cmd_tx_source", int'(got.src), int'(want.src));
          check_field("cmd_rx", int'(got.rx), int'(want.rx));
          check_field("tx_complete", int'(got.sdone), int'(want.sdone));
          check_field("rx_complete", int'(got.rdone), int'(want.rdone));
          check_field("error", int'(got.err), int'(want.err));
          check_field("pad", int'(m_tdata >> (M_ERR_LO + ERR_W)), 0);
        end
      end

      if (s_tvalid && s_tready)
        predict_link_step(s_tuser, int'(s_tdata[S_HEAD_LO +: BYTES_W]),
                          int'(s_tdata[S_TAIL_LO +: BYTES_W]),
                          int'(s_tdata[S_HLEN_LO +: HLEN_W]));
    end
    outstanding = expected_results.size();
  end

endmodule

// ===== tb/spi_link_transfer_sequencer_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the SPI link transfer sequencer: request stimulus, receive pacing and verdict.
module spi_link_transfer_sequencer_tb;
  import slts_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 335;
  localparam int N_PHASES    = 5;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata   = '0;
  logic [KIND_W-1:0]    s_tuser   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;
  logic [PHASE_W-1:0]   m_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data  = 1'b0;

  int fail_count, outstanding, results_seen, commands_seen;
  int items_sent   = 0;
  int gap_max      = 0;
  int sink_gap_max = 0;
  bit long_hold    = 1'b0;

  always #2 clk = ~clk;

  spi_link_transfer_sequencer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  slts_link_checker link_check (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .outstanding   (outstanding),
    .results_seen  (results_seen),
    .commands_seen (commands_seen)
  );

  // Offer one request after a random gap; hold it until it is taken.
  task automatic offer(input logic [KIND_W-1:0] kind, input int hb, input int tb, input int hl);
    int                   gap;
    logic [S_TDATA_W-1:0] d;
    gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
    d = '0;
    d[S_HEAD_LO +: BYTES_W] = hb[BYTES_W-1:0];
    d[S_TAIL_LO +: BYTES_W] = tb[BYTES_W-1:0];
    d[S_HLEN_LO +: HLEN_W]  = hl[HLEN_W-1:0];
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Drop the request side and wait until every result has come back.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_bidir(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // One exchange: send, receive and peer events in random order, then the phase done events.
  task automatic run_exchange();
    int order[3];
    int i, pick, tmp, hb, tb, hl, n_done;
    order = '{0, 1, 2};
    for (i = 2; i > 0; i--) begin
      pick = $urandom_range(0, i);
      tmp = order[i];
      order[i] = order[pick];
      order[pick] = tmp;
    end
    for (i = 0; i < 3; i++) begin
      case (order[i])
        0: begin
          if ($urandom_range(0, 9) != 0) begin
            case ($urandom_range(0, 9))
              0: begin hb = 0; tb = 0; end
              1: begin hb = 0; tb = 4 * $urandom_range(1, 256); end
              2: begin hb = 4 * $urandom_range(1, 256); tb = 0; end
              3: begin hb = MTU_BYTES_DEF; tb = 0; end
              4: begin hb = 0; tb = MTU_BYTES_DEF; end
              default: begin
                hb = 4 * $urandom_range(0, 256);
                tb = 4 * $urandom_range(0, (MTU_BYTES_DEF - hb) / 4);
              end
            endcase
            offer(KIND_SEND, hb, tb, $urandom_range(0, 65535));
          end
        end
        1: if ($urandom_range(0, 19) != 0)
             offer(KIND_RECV, $urandom_range(0, 2047), $urandom_range(0, 2047),
                   $urandom_range(0, 65535));
        default: offer(KIND_PEER, $urandom_range(0, 2047), $urandom_range(0, 2047),
                       $urandom_range(0, 65535));
      endcase
      // noise: any kind with unconstrained fields
      if ($urandom_range(0, 5) == 0)
        offer(KIND_W'($urandom_range(0, 3)), $urandom_range(0, 2047), $urandom_range(0, 2047),
              $urandom_range(0, 65535));
    end
    n_done = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 5) : 3;
    for (i = 0; i < n_done; i++) begin
      case ($urandom_range(0, 5))
        0: hl = 0;
        1: hl = $urandom_range(1, 64);
        2: hl = $urandom_range(0, MTU_BYTES_DEF);
        3: hl = $urandom_range(MTU_BYTES_DEF + 1, 65535);
        4: hl = 65535;
        default: hl = $urandom_range(0, 65535);
      endcase
      offer(KIND_DONE, $urandom_range(0, 2047), $urandom_range(0, 2047), hl);
    end
  endtask

  // Result side pacing, with one long hold-off on request.
  initial begin : result_sink
    int gap;
    bit held;
    held = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if (long_hold && !held) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      gap = (sink_gap_max == 0) ? 0 : $urandom_range(0, sink_gap_max);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Watchdog: no handshake for %0d cycles", QUIET_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int  base_gap, phase_start;
    bit  hold_done;
    hold_done = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    sink_gap_max = 3;
    gap_max = 2;
    write_bidir(1'b1);

    // directed: idle done, busy errors, full-size head, bad lengths
    offer(KIND_DONE, 0, 0, 0);
    offer(KIND_SEND, MTU_BYTES_DEF, 0, 0);
    offer(KIND_SEND, 4, 4, 0);
    offer(KIND_RECV, 0, 0, 0);
    offer(KIND_RECV, 0, 0, 0);
    offer(KIND_PEER, 0, 0, 0);
    offer(KIND_DONE, 0, 0, 65535);
    offer(KIND_DONE, 0, 0, 0);
    offer(KIND_SEND, 2047, 0, 0);
    offer(KIND_SEND, 512, 516, 0);
    offer(KIND_SEND, 0, 2044, 0);
    // empty exchange with a peer edge during the header phase, then a dummy release
    offer(KIND_SEND, 0, 0, 0);
    offer(KIND_PEER, 0, 0, 0);
    offer(KIND_RECV, 0, 0, 0);
    offer(KIND_PEER, 0, 0, 0);
    offer(KIND_DONE, 0, 0, 0);
    // send arriving mid-exchange is rejected as busy, since the current send is still pending
    offer(KIND_SEND, 8, 8, 0);
    offer(KIND_DONE, 0, 0, 0);
    offer(KIND_RECV, 0, 0, 0);
    offer(KIND_PEER, 0, 0, 0);
    offer(KIND_DONE, 0, 0, 7);
    offer(KIND_DONE, 0, 0, 0);
    offer(KIND_DONE, 0, 0, 0);
    // receive only: zero head goes straight to a rounded tail
    offer(KIND_PEER, 0, 0, 0);
    offer(KIND_RECV, 0, 0, 0);
    offer(KIND_DONE, 0, 0, 7);
    offer(KIND_DONE, 0, 0, 0);

    for (int ph = 0; ph < N_PHASES; ph++) begin
      settle();
      write_bidir(ph[0]);
      case (ph)
        0: begin base_gap = 12; sink_gap_max = 12; end
        1: begin base_gap = 12; sink_gap_max = 12; end
        2: begin base_gap = 0;  sink_gap_max = 0;  end
        3: begin base_gap = 0;  sink_gap_max = 12; end
        default: begin base_gap = 12; sink_gap_max = 0; end
      endcase
      phase_start = items_sent;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        if (ph == 1 && !hold_done && items_sent > phase_start + 150) begin
          long_hold = 1'b1;
          hold_done = 1'b1;
        end
        // now and then run an exchange back to back
        gap_max = (base_gap != 0 && $urandom_range(0, 4) == 0) ? 0 : base_gap;
        run_exchange();
      end
    end

    settle();
    repeat (4) @(posedge clk);
    $display("Summary: %0d requests, %0d results compared, %0d phase commands.",
             items_sent, results_seen, commands_seen);
    $display("Covered both link directions, full-rate and throttled sides, and a long hold-off.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/slts_pkg.sv
rtl/spi_link_transfer_sequencer.sv
rtl/slts_checker.sv
tb/slts_link_checker.sv
tb/spi_link_transfer_sequencer_tb.sv
